// ===== rtl/bitmap_port_allocator_defines.svh =====
// Assertion macros used by the checker file of the port allocator.
`ifndef BITMAP_PORT_ALLOCATOR_DEFINES_SVH
`define BITMAP_PORT_ALLOCATOR_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define BPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// An expression that must never be true outside reset.
`define BPA_ASSERT_NEVER(label, expr, msg) \
  `BPA_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

  localparam int MAX_WORDS = 64;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int PORT_W    = 16;
  localparam int ROW_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int UP_W      = $clog2(65536 + WORD_W * MAX_WORDS);
  localparam int WORDS_W   = 7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_IN_USE = 1'b1;

  localparam logic FN_ALLOC   = 1'b0;
  localparam logic FN_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_e;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

endpackage

// ===== rtl/bpa_bitmap.sv =====
module bpa_bitmap (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpa_pkg::mem_req_t         req_i,
  output logic [bpa_pkg::WORD_W-1:0] rdata_o
);

  // Entries never written since reset read as all free.
  logic [bpa_pkg::WORD_W-1:0]    mem [bpa_pkg::MAX_WORDS];
  logic [bpa_pkg::MAX_WORDS-1:0] valid_q;
  logic [bpa_pkg::WORD_W-1:0]    rdata_q;
  logic                          rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '1;

endmodule

// ===== rtl/bpa_ffs.sv =====
module bpa_ffs (
  input  logic [bpa_pkg::WORD_W-1:0] word_i,
  output logic [bpa_pkg::BIT_W-1:0]  idx_o
);

  always_comb begin
    logic [bpa_pkg::WORD_W-1:0] w;
    w     = word_i;
    idx_o = '0;
    if (w[15:0] == '0) begin
      w        = w >> 16;
      idx_o[4] = 1'b1;
    end
    if (w[7:0] == '0) begin
      w        = w >> 8;
      idx_o[3] = 1'b1;
    end
    if (w[3:0] == '0) begin
      w        = w >> 4;
      idx_o[2] = 1'b1;
    end
    if (w[1:0] == '0) begin
      w        = w >> 2;
      idx_o[1] = 1'b1;
    end
    if (w[0] == 1'b0) begin
      idx_o[0] = 1'b1;
    end
  end

endmodule

// ===== rtl/bitmap_port_allocator.sv =====
// Port number allocator over a bitmap of free ports, lowest port first.
// Commands enter on start_i with func_i (0 allocate, 1 release port_in_i)
// and are taken at a clock edge where start_i is high and busy_o is low.
// Each command gives one result word on status_o and port_out_o, marked
// by done_o for exactly one cycle; the receiver cannot stall it.
// An allocate reads one bitmap word per cycle from the single read port
// of the bitmap memory, starting at word 0, and answers in the cycle after
// the first non-zero word is read; at most it scans every active word
// (words_in_use, capped at 64).
// With no active word it answers without reading the bitmap.
// A release answers without a memory access when the port is out of range,
// and otherwise with one memory read, then the write back.
// A new command is taken in the cycle its predecessor's result shows.
// port_base and words_in_use are written on the cfg port; the user must write them only while idle (not enforced).
// Reset clears a valid bit per word, so every port reads as free at once
// and no clearing pass is needed.
module bitmap_port_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            func_i,
  input  logic [bpa_pkg::PORT_W-1:0]      port_in_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [bpa_pkg::PORT_W-1:0]      port_out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REL
  } state_e;

  state_e                         state_q, state_d;
  logic [bpa_pkg::ROW_W-1:0]      row_q, row_d;
  logic [bpa_pkg::BIT_W-1:0]      bit_q, bit_d;
  logic                           done_q, done_d;
  bpa_pkg::status_e               status_q, status_d;
  logic [bpa_pkg::PORT_W-1:0]     port_q, port_d;

  logic [bpa_pkg::PORT_W-1:0]     port_base_q;
  logic [bpa_pkg::WORDS_W-1:0]    words_q;

  logic [bpa_pkg::CNT_W-1:0]      n_words;
  logic [bpa_pkg::UP_W-1:0]       upper;
  logic [bpa_pkg::PORT_W-1:0]     offset;
  logic                           in_range;
  logic                           last_row;
  logic [bpa_pkg::WORD_W-1:0]     rdata;
  logic [bpa_pkg::WORD_W-1:0]     mask;
  logic [bpa_pkg::BIT_W-1:0]      col;
  bpa_pkg::mem_req_t              req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_base_q <= '0;
      words_q     <= bpa_pkg::WORDS_W'(64);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bpa_pkg::CFG_PORT_BASE) begin
        port_base_q <= cfg_wdata_i;
      end else if (cfg_idx_i == bpa_pkg::CFG_WORDS_IN_USE) begin
        words_q <= cfg_wdata_i[bpa_pkg::WORDS_W-1:0];
      end
    end
  end

  assign n_words  = (words_q > bpa_pkg::WORDS_W'(bpa_pkg::MAX_WORDS))
                  ? bpa_pkg::CNT_W'(bpa_pkg::MAX_WORDS)
                  : bpa_pkg::CNT_W'(words_q);
  assign upper    = bpa_pkg::UP_W'(port_base_q) + (bpa_pkg::UP_W'(n_words) << 5);
  assign in_range = (port_in_i >= port_base_q) && (bpa_pkg::UP_W'(port_in_i) < upper);
  assign offset   = port_in_i - port_base_q;
  assign last_row = (bpa_pkg::CNT_W'(row_q) + bpa_pkg::CNT_W'(1)) == n_words;
  assign mask     = bpa_pkg::WORD_W'(1) << bit_q;

  bpa_bitmap u_bitmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata)
  );

  bpa_ffs u_ffs (
    .word_i (rdata),
    .idx_o  (col)
  );

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    bit_d       = bit_q;
    done_d      = 1'b0;
    status_d    = status_q;
    port_d      = port_q;
    req.rd_en   = 1'b0;
    req.rd_addr = row_q;
    req.wr_en   = 1'b0;
    req.wr_addr = row_q;
    req.wr_data = rdata;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_i == bpa_pkg::FN_ALLOC) begin
            if (n_words == '0) begin
              done_d   = 1'b1;
              status_d = bpa_pkg::ST_NO_FREE;
              port_d   = '0;
            end else begin
              row_d       = '0;
              req.rd_en   = 1'b1;
              req.rd_addr = '0;
              state_d     = S_SCAN;
            end
          end else begin
            if (!in_range) begin
              done_d   = 1'b1;
              status_d = bpa_pkg::ST_RANGE;
              port_d   = '0;
            end else begin
              row_d       = offset[bpa_pkg::BIT_W +: bpa_pkg::ROW_W];
              bit_d       = offset[bpa_pkg::BIT_W-1:0];
              req.rd_en   = 1'b1;
              req.rd_addr = offset[bpa_pkg::BIT_W +: bpa_pkg::ROW_W];
              state_d     = S_REL;
            end
          end
        end
      end
      S_SCAN: begin
        if (rdata != '0) begin
          req.wr_en   = 1'b1;
          req.wr_data = rdata & ~(bpa_pkg::WORD_W'(1) << col);
          done_d      = 1'b1;
          status_d    = bpa_pkg::ST_OK;
          port_d      = port_base_q + bpa_pkg::PORT_W'({row_q, col});
          state_d     = S_IDLE;
        end else if (last_row) begin
          done_d   = 1'b1;
          status_d = bpa_pkg::ST_NO_FREE;
          port_d   = '0;
          state_d  = S_IDLE;
        end else begin
          row_d       = row_q + bpa_pkg::ROW_W'(1);
          req.rd_en   = 1'b1;
          req.rd_addr = row_q + bpa_pkg::ROW_W'(1);
        end
      end
      S_REL: begin
        done_d  = 1'b1;
        port_d  = '0;
        state_d = S_IDLE;
        if ((rdata & mask) != '0) begin
          status_d = bpa_pkg::ST_ALREADY;
        end else begin
          req.wr_en   = 1'b1;
          req.wr_data = rdata | mask;
          status_d    = bpa_pkg::ST_OK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      row_q    <= '0;
      bit_q    <= '0;
      status_q <= bpa_pkg::ST_OK;
      port_q   <= '0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      row_q    <= row_d;
      bit_q    <= bit_d;
      status_q <= status_d;
      port_q   <= port_d;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign port_out_o = port_q;

endmodule

// ===== rtl/bpa_checker.sv =====
`include "bitmap_port_allocator_defines.svh"

module bpa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic [bpa_pkg::PORT_W-1:0] port_out_o
);

  `BPA_ASSERT_NEVER(a_no_done_while_busy, busy_o && done_o, "result word while busy")
  `BPA_ASSERT(a_accept_progress, start_i && !busy_o |=> done_o || busy_o, "command dropped")
  `BPA_ASSERT(a_busy_ends_in_result, $fell(busy_o) |-> done_o, "busy ended without result")
  `BPA_ASSERT(a_fail_port_zero, done_o && status_o != bpa_pkg::ST_OK |-> port_out_o == '0, "port nonzero on failure")

endmodule

bind bitmap_port_allocator bpa_checker u_bpa_checker (.*);

// ===== test/port_alloc_checker.sv =====
module port_alloc_checker
  import bpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  busy_o,
  input  logic                  func_i,
  input  logic [PORT_W-1:0]     port_in_i,
  input  logic                  done_o,
  input  logic [1:0]            status_o,
  input  logic [PORT_W-1:0]     port_out_o,
  output int                    mismatches_o,
  output int                    pending_o
);

  typedef struct {
    logic              func;
    logic [PORT_W-1:0] arg;
    status_e           status;
    logic [PORT_W-1:0] port;
  } port_reply_t;

  logic [WORD_W-1:0]  free_map [MAX_WORDS];
  logic [PORT_W-1:0]  port_base_q;
  logic [WORDS_W-1:0] word_count_q;
  port_reply_t        due_replies [$];

  function automatic port_reply_t predict_port_op(logic func, logic [PORT_W-1:0] arg);
    port_reply_t r;
    int          rows;
    int          upper;
    int          off;
    bit          found;
    r.func   = func;
    r.arg    = arg;
    r.status = ST_OK;
    r.port   = '0;
    found    = 1'b0;
    rows     = (word_count_q > MAX_WORDS) ? MAX_WORDS : int'(word_count_q);
    if (func == FN_ALLOC) begin
      r.status = ST_NO_FREE;
      for (int row = 0; row < rows && !found; row++) begin
        for (int col = 0; col < WORD_W && !found; col++) begin
          if (free_map[row][col]) begin
            free_map[row][col] = 1'b0;
            r.port   = PORT_W'(int'(port_base_q) + row * WORD_W + col);
            r.status = ST_OK;
            found    = 1'b1;
          end
        end
      end
    end else begin
      upper = int'(port_base_q) + WORD_W * rows;
      if (int'(arg) < int'(port_base_q) || int'(arg) >= upper) begin
        r.status = ST_RANGE;
      end else begin
        off = int'(arg) - int'(port_base_q);
        if (off / WORD_W >= MAX_WORDS) begin
          r.status = ST_RANGE;
        end else if (free_map[off / WORD_W][off % WORD_W]) begin
          r.status = ST_ALREADY;
        end else begin
          free_map[off / WORD_W][off % WORD_W] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("%0t: port allocator mismatch: %s", $realtime, what);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    port_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        free_map[i] = '1;
      end
      port_base_q  = '0;
      word_count_q = WORDS_W'(64);
      due_replies.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PORT_BASE:    port_base_q  = cfg_wdata_i[PORT_W-1:0];
          CFG_WORDS_IN_USE: word_count_q = cfg_wdata_i[WORDS_W-1:0];
          default: ;
        endcase
      end
      if (done_o) begin
        if (due_replies.size() == 0) begin
          flag_mismatch($sformatf("result word status %0d port %h with no command pending",
                                  status_o, port_out_o));
        end else begin
          want = due_replies.pop_front();
          if (status_o !== want.status || port_out_o !== want.port) begin
            flag_mismatch($sformatf(
              "func %0d port_in %h: expected status %0d port %h, got status %0d port %h",
              want.func, want.arg, want.status, want.port, status_o, port_out_o));
          end
        end
      end
      if (start_i && !busy_o) begin
        due_replies.push_back(predict_port_op(func_i, port_in_i));
      end
    end
    pending_o = due_replies.size();
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import bpa_pkg::*;

  localparam int   CYCLE_LIMIT = 600000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  start_i;
  logic                  busy_o;
  logic                  func_i;
  logic [PORT_W-1:0]     port_in_i;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [PORT_W-1:0]     port_out_o;
  int                    mismatches;
  int                    pending;
  int                    cycles;
  int                    idle_pct;
  int                    cur_base;
  int                    cur_rows;

  bitmap_port_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .port_in_i   (port_in_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .port_out_o  (port_out_o)
  );

  port_alloc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .port_in_i    (port_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .port_out_o   (port_out_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic issue(input logic func, input logic [PORT_W-1:0] arg);
    bit taken;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(7, 70)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    start_i   <= 1'b1;
    func_i    <= func;
    port_in_i <= arg;
    do begin
      @(negedge clk_i);
      taken = (busy_o === 1'b0);
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // The word count is written with random upper data bits, which the block must ignore.
  task automatic reconfigure(input int base, input int words);
    drain();
    write_reg(CFG_PORT_BASE, CFG_DATA_W'(base));
    write_reg(CFG_WORDS_IN_USE,
              CFG_DATA_W'({CFG_DATA_W'($urandom) >> WORDS_W << WORDS_W} | words));
    cur_base = base;
    cur_rows = (words > MAX_WORDS) ? MAX_WORDS : words;
  endtask

  // Releases often hit the low end of the active range, where allocations land.
  task automatic random_item();
    int pick;
    int span;
    logic [PORT_W-1:0] arg;
    pick = $urandom_range(99);
    span = WORD_W * cur_rows;
    arg  = PORT_W'($urandom);
    if (pick < 55) begin
      issue(FN_ALLOC, arg);
    end else begin
      pick = $urandom_range(99);
      if (span > 0 && pick < 45) begin
        arg = PORT_W'(cur_base + $urandom_range(0, ((span < 64) ? span : 64) - 1));
      end else if (span > 0 && pick < 75) begin
        arg = PORT_W'(cur_base + $urandom_range(0, span - 1));
      end else if (pick < 87) begin
        arg = PORT_W'(($urandom_range(1) == 0) ? cur_base - 1 : cur_base + span);
      end
      issue(FN_RELEASE, arg);
    end
  endtask

  initial begin
    int base;
    int words;
    int pcts [3];
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PORT_BASE;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    func_i      = FN_ALLOC;
    port_in_i   = '0;
    idle_pct    = 0;
    cur_base    = 0;
    cur_rows    = MAX_WORDS;
    pcts        = '{28, 50, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    issue(FN_ALLOC, 16'hffff);
    issue(FN_ALLOC, 16'h0000);
    issue(FN_ALLOC, 16'h1234);
    issue(FN_RELEASE, 16'd1);
    issue(FN_RELEASE, 16'd1);
    issue(FN_ALLOC, 16'h0000);
    issue(FN_RELEASE, 16'hffff);
    issue(FN_RELEASE, 16'd2047);
    issue(FN_RELEASE, 16'd2048);

    reconfigure(16'hffff, 1);
    issue(FN_ALLOC, 16'h0000);
    issue(FN_RELEASE, 16'h0002);
    issue(FN_RELEASE, 16'hffff);
    issue(FN_ALLOC, 16'h0000);
    issue(FN_RELEASE, 16'h0000);

    reconfigure(0, 0);
    issue(FN_ALLOC, 16'h0000);
    issue(FN_RELEASE, 16'h0000);

    reconfigure(0, 127);
    issue(FN_ALLOC, 16'h0000);
    issue(FN_RELEASE, 16'd2047);
    issue(FN_RELEASE, 16'd0);
    issue(FN_ALLOC, 16'h0000);

    reconfigure(16'hf800, 64);
    issue(FN_RELEASE, 16'hffff);
    issue(FN_ALLOC, 16'h0000);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = pcts[phase];
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(9))
          0:       words = 0;
          1:       words = 1;
          2:       words = 2;
          3:       words = 127;
          4:       words = 64;
          5:       words = 3;
          6:       words = $urandom_range(65, 127);
          default: words = $urandom_range(1, 64);
        endcase
        case ($urandom_range(4))
          0:       base = 0;
          1:       base = 16'hffff;
          2:       base = 16'hffff - $urandom_range(0, 2100);
          default: base = $urandom_range(0, 16'hffff);
        endcase
        reconfigure(base, words);
        for (int n = 0; n < 50; n++) begin
          random_item();
        end
      end
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
